// ===== src/reset_pulse_sequencer_core_defines.svh =====
// Assertion macros for the reset pulse sequencer.
`ifndef RESET_PULSE_SEQUENCER_CORE_DEFINES_SVH
`define RESET_PULSE_SEQUENCER_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define RPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define RPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rps_pkg.sv =====
`default_nettype none
package rps_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] CFG_CYCLES    = 2'd1;
  localparam logic [1:0] CFG_LED_HOLD  = 2'd2;
  localparam logic [1:0] CFG_HIGH_HZ   = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Clock modes
  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LOW    = 2'd1;
  localparam logic [1:0] MODE_HIGH   = 2'd2;
  localparam logic [1:0] MODE_SERIAL = 2'd3;

  // Divider geometry: pulse_cycles * 1000 fits in 18 bits
  localparam int unsigned DVD_W     = 18;
  localparam int unsigned DVS_W     = 20;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [DVD_W-1:0] MS_PER_S     = DVD_W'(1000);
  localparam logic [DVD_W-1:0] REQ_FLOOR_MS = DVD_W'(10);
  localparam logic [DVD_W-1:0] REQ_IDLE_MS  = DVD_W'(60);
  localparam logic [DVD_W-1:0] REQ_MIN_HIGH = DVD_W'(1);

  // Reset values of the configuration registers
  localparam logic [9:0]  DEBOUNCE_RST = 10'd50;
  localparam logic [7:0]  CYCLES_RST   = 8'd6;
  localparam logic [15:0] LED_HOLD_RST = 16'd250;
  localparam logic [19:0] HIGH_HZ_RST  = 20'd1000000;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_level;
    logic        remote_request;
    logic [1:0]  clock_mode;
    logic        clock_level;
    logic [19:0] low_mode_hz;
    logic [19:0] serial_mode_hz;
  } in_item_t;

  typedef struct packed {
    logic       reset_level;
    logic       low_led;
    logic       high_led;
    logic       pulse_active;
    logic [7:0] edges_seen;
    logic       pulse_done;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } rps_div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DVD_W-1:0] quotient;
  } rps_div_rsp_t;

endpackage
`default_nettype wire

// ===== src/rps_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rps_div
  import rps_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire rps_div_req_t req,
  output rps_div_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVD_W-1:0]     dq_r, dq_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DVS_W:0]       trial;
  logic                 fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      rem_nxt  = '0;
      dq_nxt   = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      dq_nxt  = {dq_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Hold control under reset, datapath free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.quotient = dq_r;

endmodule
`default_nettype wire

// ===== src/reset_pulse_sequencer_core.sv =====
// An input transfer starts the 18-step serial divider for the timed pulse
// length; the block waits in ST_DIV until it is done, then in ST_FIN until
// the output is free, and loads the result there. One item is in flight.
// Input stall stays high from a transfer until its result is loaded.
// Reset (rst_n low at a clock edge) restores register defaults and all
// pulse, debounce and LED state; no clearing pass follows.
`default_nettype none
`include "reset_pulse_sequencer_core_defines.svh"
module reset_pulse_sequencer_core
  import rps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} st_t;

  st_t          state_r, state_nxt;
  rps_div_req_t div_req;
  rps_div_rsp_t div_rsp;

  // Configuration
  logic [9:0]  debounce_r;
  logic [7:0]  cycles_r;
  logic [15:0] led_hold_r;
  logic [19:0] high_hz_r;

  // Sequencer state
  logic        active_r, active_nxt;
  logic        level_r, level_nxt;
  logic [7:0]  edges_r, edges_nxt;
  logic [31:0] start_r, start_nxt;
  logic        edge_mode_r, edge_mode_nxt;
  logic        prev_clk_r, prev_clk_nxt;
  logic [31:0] press_r, press_nxt;
  logic [31:0] led_start_r, led_start_nxt;
  logic        led_on_r, led_on_nxt;

  in_item_t    item_r;
  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  logic             in_xfer, out_free, commit;
  logic [19:0]      divisor;
  logic [DVD_W-1:0] req_ms;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == ST_FIN) && out_free;

  // Pick the divisor for the incoming item's mode
  always_comb begin
    unique case (in_data.clock_mode)
      MODE_HIGH:   divisor = high_hz_r;
      MODE_SERIAL: divisor = in_data.serial_mode_hz;
      default:     divisor = in_data.low_mode_hz;
    endcase
  end

  assign div_req.start    = in_xfer;
  assign div_req.dividend = DVD_W'({10'd0, cycles_r} * MS_PER_S);
  assign div_req.divisor  = divisor;

  rps_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // Required pulse time from the quotient, with zero frequency and floor cases
  always_comb begin
    req_ms = REQ_IDLE_MS;
    if (item_r.clock_mode == MODE_LOW && item_r.low_mode_hz != '0) begin
      req_ms = div_rsp.quotient;
    end else if (item_r.clock_mode == MODE_HIGH && high_hz_r != '0) begin
      req_ms = (div_rsp.quotient == '0) ? REQ_MIN_HIGH : div_rsp.quotient;
    end else if (item_r.clock_mode == MODE_SERIAL && item_r.serial_mode_hz != '0) begin
      req_ms = div_rsp.quotient;
    end
    if (req_ms < REQ_FLOOR_MS) begin
      req_ms = REQ_FLOOR_MS;
    end
  end

  // Poll update: request, button, pulse, then LEDs
  always_comb begin
    logic done;
    logic high;
    active_nxt    = active_r;
    level_nxt     = level_r;
    edges_nxt     = edges_r;
    start_nxt     = start_r;
    edge_mode_nxt = edge_mode_r;
    prev_clk_nxt  = prev_clk_r;
    press_nxt     = press_r;
    led_start_nxt = led_start_r;
    led_on_nxt    = led_on_r;
    done          = 1'b0;
    high          = 1'b0;

    if (item_r.remote_request && !active_nxt) begin
      active_nxt    = 1'b1;
      edges_nxt     = '0;
      start_nxt     = item_r.now_ms;
      edge_mode_nxt = (item_r.clock_mode == MODE_STEP);
      prev_clk_nxt  = item_r.clock_level;
      level_nxt     = 1'b0;
    end

    if (item_r.button_level && ((item_r.now_ms - press_r) > {22'd0, debounce_r})) begin
      press_nxt = item_r.now_ms;
      if (!active_nxt) begin
        active_nxt    = 1'b1;
        edges_nxt     = '0;
        start_nxt     = item_r.now_ms;
        edge_mode_nxt = (item_r.clock_mode == MODE_STEP);
        prev_clk_nxt  = item_r.clock_level;
        level_nxt     = 1'b0;
      end
    end

    if (active_nxt) begin
      if (item_r.clock_mode == MODE_STEP) begin
        if (edge_mode_nxt && !prev_clk_nxt && item_r.clock_level) begin
          edges_nxt = edges_nxt + 8'd1;
          if (edges_nxt >= cycles_r) begin
            done = 1'b1;
          end
        end
        prev_clk_nxt = item_r.clock_level;
      end else if ((item_r.now_ms - start_nxt) >= {14'd0, req_ms}) begin
        done = 1'b1;
      end
      if (done) begin
        level_nxt     = 1'b1;
        active_nxt    = 1'b0;
        led_start_nxt = item_r.now_ms;
        led_on_nxt    = 1'b1;
      end
    end

    if (led_on_nxt) begin
      if ((item_r.now_ms - led_start_nxt) < {16'd0, led_hold_r}) begin
        high = 1'b1;
      end else begin
        led_on_nxt = 1'b0;
      end
    end

    out_data_nxt.reset_level  = level_nxt;
    out_data_nxt.low_led      = !level_nxt;
    out_data_nxt.high_led     = high;
    out_data_nxt.pulse_active = active_nxt;
    out_data_nxt.edges_seen   = edges_nxt;
    out_data_nxt.pulse_done   = done;
  end

  // Sequence: take item, wait on divider, commit once the output is free
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_DIV;
      ST_DIV:  if (!div_rsp.busy) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      debounce_r  <= DEBOUNCE_RST;
      cycles_r    <= CYCLES_RST;
      led_hold_r  <= LED_HOLD_RST;
      high_hz_r   <= HIGH_HZ_RST;
      active_r    <= 1'b0;
      level_r     <= 1'b1;
      edges_r     <= '0;
      start_r     <= '0;
      edge_mode_r <= 1'b0;
      prev_clk_r  <= 1'b0;
      press_r     <= '0;
      led_start_r <= '0;
      led_on_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Write configuration
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_DEBOUNCE: debounce_r <= cfg_wdata[9:0];
          CFG_CYCLES:   cycles_r   <= cfg_wdata[7:0];
          CFG_LED_HOLD: led_hold_r <= cfg_wdata[15:0];
          CFG_HIGH_HZ:  high_hz_r  <= cfg_wdata;
          default:      ;
        endcase
      end
      // Drop a taken result, load a new one on commit
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (commit) begin
        active_r    <= active_nxt;
        level_r     <= level_nxt;
        edges_r     <= edges_nxt;
        start_r     <= start_nxt;
        edge_mode_r <= edge_mode_nxt;
        prev_clk_r  <= prev_clk_nxt;
        press_r     <= press_nxt;
        led_start_r <= led_start_nxt;
        led_on_r    <= led_on_nxt;
      end
    end
    if (in_xfer) begin
      item_r <= in_data;
    end
    if (commit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RPS_ASSERT_NEXT(a_busy_after_xfer, in_xfer, in_stall, "input taken while item in flight")
  `RPS_ASSERT_NEXT(a_commit_loads, commit, out_valid, "committed result not presented")
  `RPS_ASSERT_SAME(a_done_released, out_valid && out_data.pulse_done,
                   !out_data.pulse_active && out_data.reset_level,
                   "finished pulse still holds reset")
  `RPS_ASSERT_SAME(a_led_pair, out_valid, out_data.low_led != out_data.reset_level,
                   "low LED disagrees with reset level")

endmodule
`default_nettype wire

// ===== bench/reset_pulse_sequencer_core_tb.sv =====
`timescale 1ns / 100ps
module reset_pulse_sequencer_core_tb;
  import rps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 30;

  // Mirror of the sequencer: registers, pulse state and pending results
  class pulse_scoreboard;
    logic [9:0]  debounce;
    logic [7:0]  cycles;
    logic [15:0] led_hold;
    logic [19:0] high_hz;

    logic        active;
    logic        level;
    logic        edge_mode;
    logic        prev_clk;
    logic        led_on;
    logic [7:0]  edges;
    logic [31:0] start_ms;
    logic [31:0] last_press;
    logic [31:0] led_start;

    out_item_t   expected_q[$];
    int          errors;
    int          accepted;
    int          checked;
    int          pulses_by_mode[4];

    function new();
      debounce   = DEBOUNCE_RST;
      cycles     = CYCLES_RST;
      led_hold   = LED_HOLD_RST;
      high_hz    = HIGH_HZ_RST;
      active     = 1'b0;
      level      = 1'b1;
      edge_mode  = 1'b0;
      prev_clk   = 1'b0;
      led_on     = 1'b0;
      edges      = 8'd0;
      start_ms   = 32'd0;
      last_press = 32'd0;
      led_start  = 32'd0;
      errors     = 0;
      accepted   = 0;
      checked    = 0;
      foreach (pulses_by_mode[m]) pulses_by_mode[m] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DEBOUNCE: debounce = val[9:0];
        CFG_CYCLES:   cycles   = val[7:0];
        CFG_LED_HOLD: led_hold = val[15:0];
        CFG_HIGH_HZ:  high_hz  = val;
        default: ;
      endcase
    endfunction

    function void start_pulse(in_item_t it);
      active    = 1'b1;
      edges     = 8'd0;
      start_ms  = it.now_ms;
      edge_mode = (it.clock_mode == MODE_STEP);
      prev_clk  = it.clock_level;
      level     = 1'b0;
    endfunction

    function void end_pulse(logic [31:0] now, logic [1:0] mode);
      level     = 1'b1;
      active    = 1'b0;
      led_start = now;
      led_on    = 1'b1;
      pulses_by_mode[mode]++;
    endfunction

    // Advance the state by one poll and queue the result it produces
    function void note_input(in_item_t it);
      logic [31:0] now;
      logic [31:0] cyc_ms;
      logic [31:0] need_ms;
      logic        done;
      logic        lit;
      out_item_t   res;
      now  = it.now_ms;
      done = 1'b0;
      lit  = 1'b0;
      accepted++;

      // remote request first, then the debounced button
      if (it.remote_request && !active) start_pulse(it);
      if (it.button_level && (now - last_press) > {22'd0, debounce}) begin
        last_press = now;
        if (!active) start_pulse(it);
      end

      if (active) begin
        if (it.clock_mode == MODE_STEP) begin
          // count rising edges only for pulses begun in single step mode
          if (edge_mode && !prev_clk && it.clock_level) begin
            edges = edges + 8'd1;
            if (edges >= cycles) begin
              end_pulse(now, it.clock_mode);
              done = 1'b1;
            end
          end
          prev_clk = it.clock_level;
        end else begin
          cyc_ms = {24'd0, cycles} * 32'd1000;
          case (it.clock_mode)
            MODE_LOW: begin
              need_ms = (it.low_mode_hz != 0) ? cyc_ms / {12'd0, it.low_mode_hz} : 32'd60;
            end
            MODE_HIGH: begin
              if (high_hz != 0) begin
                need_ms = cyc_ms / {12'd0, high_hz};
                if (need_ms == 0) need_ms = 32'd1;
              end else begin
                need_ms = 32'd60;
              end
            end
            default: begin
              need_ms = (it.serial_mode_hz != 0) ? cyc_ms / {12'd0, it.serial_mode_hz} : 32'd60;
            end
          endcase
          if (need_ms < 32'd10) need_ms = 32'd10;
          if ((now - start_ms) >= need_ms) begin
            end_pulse(now, it.clock_mode);
            done = 1'b1;
          end
        end
      end

      // high LED stays lit for the hold time, then goes dark until the next pulse
      if (led_on) begin
        if ((now - led_start) < {16'd0, led_hold}) lit = 1'b1;
        else led_on = 1'b0;
      end

      res.reset_level  = level;
      res.low_led      = ~level;
      res.high_led     = lit;
      res.pulse_active = active;
      res.edges_seen   = edges;
      res.pulse_done   = done;
      expected_q.push_back(res);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      check_field("reset_level", want.reset_level, got.reset_level);
      check_field("low_led", want.low_led, got.low_led);
      check_field("high_led", want.high_led, got.high_led);
      check_field("pulse_active", want.pulse_active, got.pulse_active);
      check_field("edges_seen", want.edges_seen, got.edges_seen);
      check_field("pulse_done", want.pulse_done, got.pulse_done);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  pulse_scoreboard sb = new();

  int          cycle_cnt = 0;
  int          sent = 0;
  int          burst_left = 0;
  int          settings = 1;
  logic [31:0] t_ms = 32'd0;
  logic        cur_clk = 1'b0;
  logic        hold_req = 1'b0;
  int          hold_left = 0;
  int          stall_mode = 0;
  int          stall_left = 0;

  reset_pulse_sequencer_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stall: long hold-off on request, otherwise a changing pattern
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall = 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(50, 400);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 99) < 30);
        2: out_stall = ($urandom_range(0, 99) < 75);
        default: out_stall = ((cycle_cnt % 7) < 4);
      endcase
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Drop valid; n sets how long
  task automatic idle(int n);
    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Offer one poll within the current burst and wait for its transfer
  task automatic send(in_item_t it);
    if (burst_left == 0) begin
      idle(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    sent++;
  endtask

  // Hold until every expected result has arrived and the block is quiet
  task automatic drain();
    idle(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic load_settings(logic [9:0] deb, logic [7:0] cyc, logic [15:0] hold,
                               logic [19:0] hz);
    write_cfg(CFG_DEBOUNCE, {10'd0, deb});
    write_cfg(CFG_CYCLES, {12'd0, cyc});
    write_cfg(CFG_LED_HOLD, {4'd0, hold});
    write_cfg(CFG_HIGH_HZ, hz);
    settings++;
  endtask

  function automatic in_item_t poll(logic [31:0] now, logic btn, logic req,
                                    logic [1:0] mode, logic lvl,
                                    logic [19:0] low_hz, logic [19:0] ser_hz);
    in_item_t it;
    it.now_ms         = now;
    it.button_level   = btn;
    it.remote_request = req;
    it.clock_mode     = mode;
    it.clock_level    = lvl;
    it.low_mode_hz    = low_hz;
    it.serial_mode_hz = ser_hz;
    return it;
  endfunction

  function automatic logic [19:0] pick_hz();
    case ($urandom_range(0, 3))
      0: return 20'd0;
      1: return 20'($urandom_range(200, 2000));
      2: return 20'($urandom_range(1, 20'hFFFFF));
      default: return 20'($urandom_range(1, 100));
    endcase
  endfunction

  // Mostly press/request followed by a run of polls; some random noise polls
  task automatic run_random(int count);
    int          stop_at;
    int          len;
    logic        held;
    logic        trig_btn;
    logic [1:0]  mode;
    logic [19:0] lo_hz;
    logic [19:0] sr_hz;
    in_item_t    it;
    stop_at = sent + count;
    held    = 1'b0;
    while (sent < stop_at) begin
      // halfway through, let the receiver back up the block
      if (!held && sent >= stop_at - count / 2) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        it.now_ms         = $urandom();
        it.button_level   = 1'($urandom_range(0, 1));
        it.remote_request = 1'($urandom_range(0, 1));
        it.clock_mode     = 2'($urandom_range(0, 3));
        it.clock_level    = 1'($urandom_range(0, 1));
        it.low_mode_hz    = 20'($urandom_range(0, 20'hFFFFF));
        it.serial_mode_hz = 20'($urandom_range(0, 20'hFFFFF));
        send(it);
        t_ms    = it.now_ms;
        cur_clk = it.clock_level;
      end else begin
        mode     = 2'($urandom_range(0, 3));
        lo_hz    = pick_hz();
        sr_hz    = pick_hz();
        len      = $urandom_range(2, 24);
        trig_btn = 1'($urandom_range(0, 1));
        for (int k = 0; k < len && sent < stop_at; k++) begin
          case ($urandom_range(0, 49))
            0: t_ms = $urandom();
            1, 2, 3, 4, 5: t_ms = t_ms + $urandom_range(0, 400);
            default: t_ms = t_ms + $urandom_range(0, 12);
          endcase
          if ($urandom_range(0, 19) == 0) mode = 2'($urandom_range(0, 3));
          if (mode == MODE_STEP && $urandom_range(0, 4) != 0) cur_clk = ~cur_clk;
          else cur_clk = 1'($urandom_range(0, 1));
          it.now_ms         = t_ms;
          it.button_level   = (k == 0) ? trig_btn : ($urandom_range(0, 7) == 0);
          it.remote_request = (k == 0) ? !trig_btn : ($urandom_range(0, 11) == 0);
          it.clock_mode     = mode;
          it.clock_level    = cur_clk;
          it.low_mode_hz    = lo_hz;
          it.serial_mode_hz = sr_hz;
          send(it);
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Register defaults: debounce window, every clock mode, LED hold edges
    send(poll(32'd0, 1'b1, 1'b0, MODE_LOW, 1'b0, 20'd0, 20'd0));
    send(poll(32'd10, 1'b0, 1'b1, MODE_LOW, 1'b0, 20'd0, 20'd0));
    send(poll(32'd60, 1'b1, 1'b0, MODE_LOW, 1'b1, 20'd0, 20'd0));
    send(poll(32'd70, 1'b0, 1'b0, MODE_LOW, 1'b0, 20'd0, 20'd0));
    send(poll(32'd319, 1'b0, 1'b0, MODE_LOW, 1'b0, 20'd0, 20'd0));
    send(poll(32'd320, 1'b0, 1'b0, MODE_LOW, 1'b0, 20'd0, 20'd0));
    send(poll(32'd400, 1'b0, 1'b1, MODE_HIGH, 1'b0, 20'd0, 20'd0));
    send(poll(32'd409, 1'b0, 1'b0, MODE_HIGH, 1'b1, 20'd0, 20'd0));
    send(poll(32'd410, 1'b0, 1'b0, MODE_HIGH, 1'b0, 20'd0, 20'd0));
    send(poll(32'd500, 1'b0, 1'b1, MODE_SERIAL, 1'b0, 20'd0, 20'hFFFFF));
    send(poll(32'd510, 1'b0, 1'b0, MODE_SERIAL, 1'b0, 20'd0, 20'hFFFFF));
    // pulse begun in a timed mode does not count edges in single step mode
    send(poll(32'd600, 1'b0, 1'b1, MODE_LOW, 1'b0, 20'd1000, 20'd0));
    send(poll(32'd700, 1'b0, 1'b0, MODE_STEP, 1'b1, 20'd1000, 20'd0));
    send(poll(32'd701, 1'b0, 1'b0, MODE_STEP, 1'b0, 20'd1000, 20'd0));
    send(poll(32'd702, 1'b0, 1'b0, MODE_STEP, 1'b1, 20'd1000, 20'd0));
    send(poll(32'd703, 1'b0, 1'b0, MODE_LOW, 1'b0, 20'd1000, 20'd0));
    drain();

    // Zero registers: first edge ends the pulse, no LED, zero high frequency
    load_settings(10'd0, 8'd0, 16'd0, 20'd0);
    send(poll(32'd1000, 1'b1, 1'b0, MODE_STEP, 1'b0, 20'd0, 20'd0));
    send(poll(32'd1001, 1'b1, 1'b0, MODE_STEP, 1'b1, 20'd0, 20'd0));
    send(poll(32'd1002, 1'b1, 1'b1, MODE_HIGH, 1'b0, 20'd0, 20'd0));
    send(poll(32'd1062, 1'b0, 1'b0, MODE_HIGH, 1'b0, 20'd0, 20'd0));
    // time wraps through zero during a pulse
    send(poll(32'hFFFF_FFF0, 1'b0, 1'b1, MODE_LOW, 1'b1, 20'hFFFFF, 20'd0));
    send(poll(32'h0000_0005, 1'b0, 1'b0, MODE_LOW, 1'b0, 20'hFFFFF, 20'd0));
    drain();

    // Random phases, extreme settings first
    load_settings(10'd1023, 8'd255, 16'hFFFF, 20'hFFFFF);
    run_random(125);
    drain();
    load_settings(10'd0, 8'd1, 16'd1, 20'd1);
    run_random(125);
    drain();
    repeat (4) begin
      load_settings(10'($urandom_range(0, 200)), 8'($urandom_range(1, 8)),
                    16'($urandom_range(0, 600)),
                    $urandom_range(0, 1) ? 20'd1000000 : 20'($urandom_range(1, 20'hFFFFF)));
      run_random(125);
      drain();
    end

    $display("Run covered %0d polls and %0d checked results over %0d register settings",
             sb.accepted, sb.checked, settings);
    $display("Pulses ended: single step %0d, low %0d, high %0d, serial %0d",
             sb.pulses_by_mode[0], sb.pulses_by_mode[1], sb.pulses_by_mode[2],
             sb.pulses_by_mode[3]);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
